### rtl/ilir_pkg.sv
// Shared constants, codes and types of the indexed list block.
package ilir_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    localparam int IN_FIELDS_W  = MODE_W + POS_W + DATA_W;
    localparam int OUT_FIELDS_W = DATA_W + CNT_W + STAT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MOVE,
        S_READ,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [CNT_W-1:0] next;
        logic             more;
    } t_step;

endpackage

### rtl/indexed_list_insert_remove_top.sv
// Top level of the indexed list: sequencer, shared index unit and entry store.
// Keeps an ordered list of up to 64 signed 32-bit values. Each request word
// appends, inserts, removes, reads or overwrites and returns one result word
// with the value read, the count after the request and a status; full-list
// and out-of-range requests are refused and change nothing. One request is
// handled at a time. Append, overwrite and refused requests go from idle to
// the finish state that loads the result word, a read via the read state.
// Insert and remove move entries one at a time through the store's one read
// port and one write port, read in the shift state and written in the move
// state. Insert at p with n stored moves n - p entries, remove n - p - 1.
// The input is ready again once the result word is loaded; a finished
// result may wait in the output register while the next request is accepted.
module indexed_list_insert_remove_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mode [2:0], position [9:3], value [41:10], zero fill above
    input  logic [ilir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_value [31:0], count [38:32], status [40:39], zero fill above
    output logic [ilir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ilir_pkg::*;

    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    ilir_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mem_req     (mem_req),
        .i_mem_rdata   (mem_rdata)
    );

    ilir_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

### rtl/ilir_mem.sv
// Entry store: one write port and one read port with registered read data.
module ilir_mem (
    input  logic                         i_clk,
    input  ilir_pkg::t_mem_req           i_req,
    output logic [ilir_pkg::DATA_W-1:0]  o_rdata
);
    import ilir_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ilir_step.sv
// Shared index unit: one increment or decrement and the loop-end compare.
module ilir_step (
    input  logic [ilir_pkg::CNT_W-1:0] i_idx,
    input  logic [ilir_pkg::CNT_W-1:0] i_limit,
    input  logic                       i_down,
    output ilir_pkg::t_step            o_step
);
    import ilir_pkg::*;

    logic [CNT_W-1:0] step_sum;

    assign step_sum = i_down ? (i_idx - CNT_W'(1)) : (i_idx + CNT_W'(1));

    always_comb begin
        o_step.next = step_sum;
        // Downward runs stop at the limit, upward runs stop one short of it
        o_step.more = i_down ? (i_idx > i_limit) : (step_sum < i_limit);
    end

endmodule

### rtl/ilir_ctrl.sv
// Request sequencer: checks, entry shifting, result register and handshakes.
module ilir_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ilir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ilir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output ilir_pkg::t_mem_req                o_mem_req,
    input  logic [ilir_pkg::DATA_W-1:0]       i_mem_rdata
);
    import ilir_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic [STAT_W-1:0] r_status, n_status;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [MODE_W-1:0] in_mode;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_val;
    logic [STAT_W-1:0] in_status;
    logic              in_accept;
    logic              is_full;
    logic              step_down;
    logic [CNT_W-1:0]  step_limit;
    t_step             step;

    assign in_mode = s_axis_tdata[MODE_W-1:0];
    assign in_pos  = s_axis_tdata[MODE_W+POS_W-1:MODE_W];
    assign in_val  = s_axis_tdata[IN_FIELDS_W-1:MODE_W+POS_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_full       = (r_count == CAP_COUNT);

    assign step_down  = (r_mode == MODE_INSERT);
    assign step_limit = step_down ? r_pos : r_count;

    ilir_step u_step (
        .i_idx   (r_idx),
        .i_limit (step_limit),
        .i_down  (step_down),
        .o_step  (step)
    );

    // Status of the incoming request against the current count
    always_comb begin
        case (in_mode)
            MODE_APPEND: in_status = is_full ? ST_FULL : ST_DONE;
            MODE_INSERT: begin
                if (is_full) begin
                    in_status = ST_FULL;
                end else if (in_pos > r_count) begin
                    in_status = ST_RANGE;
                end else begin
                    in_status = ST_DONE;
                end
            end
            MODE_REMOVE, MODE_READ, MODE_WRITE:
                in_status = (in_pos >= r_count) ? ST_RANGE : ST_DONE;
            default: in_status = ST_DONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_val       = r_val;
        n_rd        = r_rd;
        n_status    = r_status;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_idx[ADDR_W-1:0];
        o_mem_req.wdata = i_mem_rdata;
        o_mem_req.raddr = r_pos[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_mode   = in_mode;
                    n_pos    = in_pos;
                    n_val    = in_val;
                    n_rd     = '0;
                    n_status = in_status;
                    n_state  = S_FINISH;
                    if (in_status == ST_DONE) begin
                        case (in_mode)
                            MODE_APPEND: begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_count[ADDR_W-1:0];
                                o_mem_req.wdata = in_val;
                                n_count         = r_count + CNT_W'(1);
                            end
                            MODE_WRITE: begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = in_pos[ADDR_W-1:0];
                                o_mem_req.wdata = in_val;
                            end
                            MODE_READ: begin
                                o_mem_req.raddr = in_pos[ADDR_W-1:0];
                                n_state         = S_READ;
                            end
                            MODE_INSERT: begin
                                n_idx   = r_count;
                                n_state = S_SHIFT;
                            end
                            MODE_REMOVE: begin
                                n_idx   = in_pos;
                                n_state = S_SHIFT;
                            end
                            default: n_state = S_FINISH;
                        endcase
                    end
                end
            end
            S_SHIFT: begin
                if (step.more) begin
                    // Fetch the neighbour that moves into the current slot
                    o_mem_req.raddr = step.next[ADDR_W-1:0];
                    n_state         = S_MOVE;
                end else begin
                    if (step_down) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_pos[ADDR_W-1:0];
                        o_mem_req.wdata = r_val;
                        n_count         = r_count + CNT_W'(1);
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                    n_state = S_FINISH;
                end
            end
            S_MOVE: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_idx[ADDR_W-1:0];
                o_mem_req.wdata = i_mem_rdata;
                n_idx           = step.next;
                n_state         = S_SHIFT;
            end
            S_READ: begin
                n_rd    = i_mem_rdata;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the result register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_status, r_count, r_rd});
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_mode     <= n_mode;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_rd       <= n_rd;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_COUNT)
        else $error("element count above capacity");

    a_insert_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_mode == MODE_INSERT) |-> (r_idx >= r_pos && r_idx <= r_count))
        else $error("insert shift index outside its run");

    a_remove_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_mode == MODE_REMOVE) |-> (r_idx + CNT_W'(1) < r_count))
        else $error("remove shift index outside the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_status == ST_FULL) |-> is_full)
        else $error("full status with room left");

    a_refused_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && $past(r_state) == S_IDLE && r_status != ST_DONE)
            |-> $stable(r_count))
        else $error("refused request changed the count");
`endif

endmodule
